// ===== rtl/abt_pkg.sv =====
// Package for the action binding table: sizes, command codes, state encoding.
// No dependencies.
package abt_pkg;
  localparam int NUM_ACTIONS = 16;
  localparam int GROUP_BITS  = 4;
  localparam int IDX_W       = $clog2(NUM_ACTIONS);
  localparam int CNT_W       = $clog2(NUM_ACTIONS + 1);
  localparam int KEY_W       = 11;
  localparam int PAD_W       = 6;

  typedef enum logic [2:0] {
    CMD_SET_CAT = 3'd0,
    CMD_MAP_KEY = 3'd1,
    CMD_MAP_ALT = 3'd2,
    CMD_MAP_PAD = 3'd3,
    CMD_KEY_EVT = 3'd4,
    CMD_PAD_EVT = 3'd5,
    CMD_TICK    = 3'd6,
    CMD_QUERY   = 3'd7
  } cmd_t;

  localparam logic [1:0] PS_PRESS   = 2'd0;
  localparam logic [1:0] PS_RELEASE = 2'd1;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_FIND     = 6'b000010,
    S_APPLY    = 6'b000100,
    S_CONFLICT = 6'b001000,
    S_SCAN     = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;
endpackage

// ===== rtl/action_binding_table.sv =====
// Action binding table top level: entry storage and scan sequencer.
// Depends on abt_pkg.
// Transactions scan the table one entry per cycle, driven by a single index counter:
// events and tick take one scan pass, query one find pass, map commands a find pass,
// an update step and a conflict pass that stops at the first conflict; set-category and
// a full table skip the conflict pass, pad commands with a code above 31 skip all passes.
// A new transaction is accepted only after the previous result has been taken.
module action_binding_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [15:0] action_id,
  input  logic [9:0]  button_code,
  input  logic [3:0]  category,
  input  logic [1:0]  press_state,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        conflict_valid,
  output logic [15:0] conflict_action_id,
  output logic        action_down,
  output logic        action_released,
  output logic        table_full
);
  import abt_pkg::*;

  state_t state;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] used_count;

  logic [15:0]           slot_action  [NUM_ACTIONS];
  logic [GROUP_BITS-1:0] slot_group   [NUM_ACTIONS];
  logic [KEY_W-1:0]      slot_key     [NUM_ACTIONS];
  logic [KEY_W-1:0]      slot_alt_key [NUM_ACTIONS];
  logic [PAD_W-1:0]      slot_pad     [NUM_ACTIONS];
  logic [2:0]            slot_marks   [NUM_ACTIONS];

  cmd_t             r_cmd;
  logic [15:0]      r_id;
  logic [9:0]       r_code;
  logic [GROUP_BITS-1:0] r_cat;
  logic [1:0]       r_ps;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [GROUP_BITS-1:0] hit_group;
  logic [KEY_W-1:0] hit_key;
  logic [KEY_W-1:0] hit_alt;
  logic [PAD_W-1:0] hit_pad;
  logic [2:0]       hit_marks;
  logic [GROUP_BITS-1:0] s_group;

  logic [KEY_W-1:0] kc;
  logic [PAD_W-1:0] pc;
  logic             in_use, last, key_m, alt_m, pad_m, same_grp, cand, found;
  logic [IDX_W-1:0] s_idx;
  logic [KEY_W-1:0] base_key, base_alt;
  logic [PAD_W-1:0] base_pad;
  logic [GROUP_BITS-1:0] base_grp;
  logic [2:0]       base_marks;

  assign kc       = {1'b1, r_code};
  assign pc       = {1'b1, r_code[4:0]};
  assign in_use   = {1'b0, idx} < used_count;
  assign last     = idx == IDX_W'(NUM_ACTIONS - 1);
  assign key_m    = slot_key[idx] == kc;
  assign alt_m    = slot_alt_key[idx] == kc;
  assign pad_m    = slot_pad[idx] == pc;
  assign same_grp = slot_group[idx] == s_group;
  assign cand     = in_use && slot_action[idx] != r_id && same_grp;
  assign found    = cand && ((r_cmd == CMD_MAP_PAD) ? pad_m : (key_m || alt_m));
  assign s_idx    = hit ? hit_idx : used_count[IDX_W-1:0];
  assign base_key = hit ? hit_key : '0;
  assign base_alt = hit ? hit_alt : '0;
  assign base_pad = hit ? hit_pad : '0;
  assign base_grp = hit ? hit_group : '0;
  assign base_marks = hit ? hit_marks : '0;
  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      idx        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_cmd  <= cmd_t'(cmd);
            r_id   <= action_id;
            r_code <= button_code;
            r_cat  <= GROUP_BITS'(category);
            r_ps   <= press_state;
            idx    <= '0;
            hit    <= 1'b0;
            conflict_valid     <= 1'b0;
            conflict_action_id <= '0;
            action_down        <= 1'b0;
            action_released    <= 1'b0;
            table_full         <= 1'b0;
            if ((cmd == CMD_MAP_PAD || cmd == CMD_PAD_EVT) && button_code[9:5] != 5'd0)
              state <= S_DONE;
            else if (cmd == CMD_KEY_EVT || cmd == CMD_PAD_EVT || cmd == CMD_TICK)
              state <= S_SCAN;
            else
              state <= S_FIND;
          end
        end
        S_FIND: begin
          if (!hit && in_use && slot_action[idx] == r_id) begin
            hit       <= 1'b1;
            hit_idx   <= idx;
            hit_group <= slot_group[idx];
            hit_key   <= slot_key[idx];
            hit_alt   <= slot_alt_key[idx];
            hit_pad   <= slot_pad[idx];
            hit_marks <= slot_marks[idx];
          end
          idx <= idx + 1'b1;
          if (last) state <= (r_cmd == CMD_QUERY) ? S_DONE : S_APPLY;
          if (last && r_cmd == CMD_QUERY) begin
            if (!hit && in_use && slot_action[idx] == r_id) begin
              action_down     <= slot_marks[idx][0];
              action_released <= slot_marks[idx][2];
            end else if (hit) begin
              action_down     <= hit_marks[0];
              action_released <= hit_marks[2];
            end
          end
        end
        S_APPLY: begin
          idx <= '0;
          if (!hit && used_count == CNT_W'(NUM_ACTIONS)) begin
            table_full <= 1'b1;
            state      <= S_DONE;
          end else begin
            if (!hit) used_count <= used_count + 1'b1;
            slot_action[s_idx]  <= r_id;
            slot_group[s_idx]   <= (r_cmd == CMD_SET_CAT) ? r_cat : base_grp;
            slot_key[s_idx]     <= (r_cmd == CMD_MAP_KEY) ? kc :
                                   (r_cmd == CMD_MAP_ALT && base_key == kc) ? '0 : base_key;
            slot_alt_key[s_idx] <= (r_cmd == CMD_MAP_ALT) ? kc :
                                   (r_cmd == CMD_MAP_KEY && base_alt == kc) ? '0 : base_alt;
            slot_pad[s_idx]     <= (r_cmd == CMD_MAP_PAD) ? pc : base_pad;
            slot_marks[s_idx]   <= base_marks;
            s_group <= base_grp;
            state <= (r_cmd == CMD_SET_CAT) ? S_DONE : S_CONFLICT;
          end
        end
        S_CONFLICT: begin
          idx <= idx + 1'b1;
          if (last || found) state <= S_DONE;
          if (cand) begin
            if (r_cmd == CMD_MAP_PAD) begin
              if (pad_m) begin
                slot_pad[idx]      <= '0;
                conflict_valid     <= 1'b1;
                conflict_action_id <= slot_action[idx];
              end
            end else if (key_m) begin
              slot_key[idx]      <= '0;
              conflict_valid     <= 1'b1;
              conflict_action_id <= slot_action[idx];
            end else if (alt_m) begin
              slot_alt_key[idx]  <= '0;
              conflict_valid     <= 1'b1;
              conflict_action_id <= slot_action[idx];
            end
          end
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          if (last) state <= S_DONE;
          if (in_use) begin
            if (r_cmd == CMD_TICK) begin
              if (slot_marks[idx][1]) slot_marks[idx] <= {1'b1, 1'b0, slot_marks[idx][0]};
              else slot_marks[idx][2] <= 1'b0;
            end else if ((r_cmd == CMD_KEY_EVT) ? (key_m || alt_m) : pad_m) begin
              if (r_ps == PS_PRESS) slot_marks[idx][0] <= 1'b1;
              else if (r_ps == PS_RELEASE) slot_marks[idx][1:0] <= 2'b10;
            end
          end
        end
        S_DONE: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(NUM_ACTIONS)) else $error("used_count overflow");
  a_full_no_conflict: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !conflict_valid) else $error("full with conflict");
  a_query_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action_down || action_released) |-> r_cmd == CMD_QUERY)
    else $error("query flags on other command");
  a_insert_step: assert property (@(posedge clk) disable iff (rst)
    used_count != $past(used_count) |-> $past(state) == S_APPLY)
    else $error("count changed outside update");
endmodule

// ===== verif/tb.sv =====
// Testbench for action_binding_table: random and directed command transactions,
// checked against an in-bench predictor of the binding table. Depends on abt_pkg.
module tb;
  import abt_pkg::*;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] id;
    logic [9:0]  code;
    logic [3:0]  cat;
    logic [1:0]  ps;
  } req_t;

  typedef struct packed {
    logic        cv;
    logic [15:0] cid;
    logic        down;
    logic        rel;
    logic        full;
  } rsp_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] cmd = 0;
  logic [15:0] action_id = 0;
  logic [9:0] button_code = 0;
  logic [3:0] category = 0;
  logic [1:0] press_state = 0;
  logic out_valid;
  logic out_ready = 0;
  logic conflict_valid, action_down, action_released, table_full;
  logic [15:0] conflict_action_id;

  action_binding_table DUT (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  bit          ent_used [NUM_ACTIONS];
  logic [15:0] ent_id   [NUM_ACTIONS];
  logic [3:0]  ent_grp  [NUM_ACTIONS];
  logic [10:0] ent_key  [NUM_ACTIONS];
  logic [10:0] ent_alt  [NUM_ACTIONS];
  logic [5:0]  ent_pad  [NUM_ACTIONS];
  logic [2:0]  ent_mark [NUM_ACTIONS];
  int          ent_cnt;

  req_t pending[$];
  rsp_t expected[$];
  int in_idle_pct, out_stall_pct;
  int mismatches;
  int cycles;

  function automatic int lookup(logic [15:0] id);
    for (int i = 0; i < NUM_ACTIONS; i++)
      if (ent_used[i] && ent_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void press(int i, logic [1:0] ps);
    if (ps == PS_PRESS) ent_mark[i][0] = 1;
    else if (ps == PS_RELEASE) begin
      ent_mark[i][0] = 0;
      ent_mark[i][1] = 1;
    end
  endfunction

  function automatic rsp_t bind_step(req_t r);
    rsp_t o;
    int s;
    logic [2:0] c;
    logic [10:0] kc;
    logic [5:0] pc;
    o = '0;
    c = r.cmd;
    kc = {1'b1, r.code};
    pc = {1'b1, r.code[4:0]};
    if ((c == CMD_MAP_PAD || c == CMD_PAD_EVT) && r.code > 31) return o;
    if (c <= CMD_MAP_PAD) begin
      s = lookup(r.id);
      if (s < 0) begin
        if (ent_cnt >= NUM_ACTIONS) begin
          o.full = 1;
          return o;
        end
        s = ent_cnt;
        ent_used[s] = 1; ent_id[s] = r.id; ent_grp[s] = 0;
        ent_key[s] = 0; ent_alt[s] = 0; ent_pad[s] = 0; ent_mark[s] = 0;
        ent_cnt++;
      end
      if (c == CMD_SET_CAT) ent_grp[s] = r.cat;
      else begin
        if (c == CMD_MAP_KEY) begin
          if (ent_alt[s] == kc) ent_alt[s] = 0;
          ent_key[s] = kc;
        end else if (c == CMD_MAP_ALT) begin
          if (ent_key[s] == kc) ent_key[s] = 0;
          ent_alt[s] = kc;
        end else ent_pad[s] = pc;
        for (int i = 0; i < ent_cnt; i++) begin
          if (!ent_used[i] || ent_id[i] == r.id || ent_grp[i] != ent_grp[s]) continue;
          if (c == CMD_MAP_PAD) begin
            if (ent_pad[i] == pc) begin
              ent_pad[i] = 0; o.cv = 1; o.cid = ent_id[i]; break;
            end
          end else if (ent_key[i] == kc) begin
            ent_key[i] = 0; o.cv = 1; o.cid = ent_id[i]; break;
          end else if (ent_alt[i] == kc) begin
            ent_alt[i] = 0; o.cv = 1; o.cid = ent_id[i]; break;
          end
        end
      end
    end else if (c == CMD_KEY_EVT) begin
      for (int i = 0; i < NUM_ACTIONS; i++)
        if (ent_used[i] && (ent_key[i] == kc || ent_alt[i] == kc)) press(i, r.ps);
    end else if (c == CMD_PAD_EVT) begin
      for (int i = 0; i < NUM_ACTIONS; i++)
        if (ent_used[i] && ent_pad[i] == pc) press(i, r.ps);
    end else if (c == CMD_TICK) begin
      for (int i = 0; i < NUM_ACTIONS; i++) begin
        if (!ent_used[i]) continue;
        if (ent_mark[i][1]) begin
          ent_mark[i][2] = 1;
          ent_mark[i][1] = 0;
        end else ent_mark[i][2] = 0;
      end
    end else begin
      s = lookup(r.id);
      if (s >= 0) begin
        o.down = ent_mark[s][0];
        o.rel = ent_mark[s][2];
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && in_ready)
        expected.insert(expected.size(), bind_step({cmd, action_id, button_code,
                                                    category, press_state}));
      if (!in_valid || in_ready) begin
        if (pending.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          req_t r;
          r = pending.pop_front();
          in_valid <= 1;
          cmd <= r.cmd; action_id <= r.id; button_code <= r.code;
          category <= r.cat; press_state <= r.ps;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        rsp_t got, exp_r;
        got = {conflict_valid, conflict_action_id, action_down, action_released, table_full};
        if (expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %h", got);
        end else begin
          exp_r = expected.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp cv=%b cid=%h dn=%b rel=%b full=%b got cv=%b cid=%h dn=%b rel=%b full=%b",
                       exp_r.cv, exp_r.cid, exp_r.down, exp_r.rel, exp_r.full,
                       got.cv, got.cid, got.down, got.rel, got.full);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 1500000) begin
      $display("FAIL");
      $finish;
    end
  end

  logic [15:0] id_pool [24];

  function automatic req_t mk(logic [2:0] c, logic [15:0] id, logic [9:0] code,
                              logic [3:0] cat, logic [1:0] ps);
    req_t r;
    r.cmd = c; r.id = id; r.code = code; r.cat = cat; r.ps = ps;
    return r;
  endfunction

  task automatic enqueue(req_t r);
    pending.insert(pending.size(), r);
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected.size() > 0) @(posedge clk);
  endtask

  task automatic fill_random(int n);
    req_t r;
    for (int k = 0; k < n; k++) begin
      r.cmd = $urandom_range(7);
      r.id = ($urandom_range(9) == 0) ? 16'($urandom) : id_pool[$urandom_range(23)];
      r.code = ($urandom_range(5) == 0) ? 10'($urandom) : 10'($urandom_range(7) * 147 % 32);
      if (r.cmd == CMD_KEY_EVT || r.cmd == CMD_MAP_KEY || r.cmd == CMD_MAP_ALT)
        if ($urandom_range(3) == 0) r.code = {5'($urandom), r.code[4:0]};
      r.cat = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(1));
      r.ps = ($urandom_range(7) == 0) ? 2'($urandom) : 2'($urandom_range(1));
      enqueue(r);
    end
  endtask

  initial begin
    for (int i = 0; i < 24; i++) id_pool[i] = (i == 0) ? 16'h0000 :
                                               (i == 1) ? 16'hFFFF : 16'($urandom);
    in_idle_pct = 0; out_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    enqueue(mk(CMD_QUERY, 16'h1234, 0, 0, 0));
    enqueue(mk(CMD_MAP_KEY, 16'h0000, 10'h3FF, 0, 0));
    enqueue(mk(CMD_MAP_ALT, 16'hFFFF, 10'h3FF, 0, 0));
    enqueue(mk(CMD_MAP_ALT, 16'h0000, 10'h3FF, 0, 0));
    enqueue(mk(CMD_MAP_KEY, 16'h0000, 10'h3FF, 0, 0));
    enqueue(mk(CMD_MAP_PAD, 16'h0001, 10'd31, 0, 0));
    enqueue(mk(CMD_MAP_PAD, 16'h0002, 10'd31, 0, 0));
    enqueue(mk(CMD_MAP_PAD, 16'h0002, 10'd32, 0, 0));
    enqueue(mk(CMD_SET_CAT, 16'h0001, 0, 4'hF, 0));
    enqueue(mk(CMD_PAD_EVT, 16'h0, 10'd31, 0, PS_PRESS));
    enqueue(mk(CMD_PAD_EVT, 16'h0, 10'd40, 0, PS_PRESS));
    enqueue(mk(CMD_KEY_EVT, 16'h0, 10'h3FF, 0, PS_PRESS));
    enqueue(mk(CMD_QUERY, 16'h0000, 0, 0, 0));
    enqueue(mk(CMD_KEY_EVT, 16'h0, 10'h3FF, 0, 2'd3));
    enqueue(mk(CMD_KEY_EVT, 16'h0, 10'h3FF, 0, PS_RELEASE));
    enqueue(mk(CMD_TICK, 16'h0, 0, 0, 0));
    enqueue(mk(CMD_QUERY, 16'h0000, 0, 0, 0));
    enqueue(mk(CMD_TICK, 16'h0, 0, 0, 0));
    enqueue(mk(CMD_QUERY, 16'h0000, 0, 0, 0));
    for (int i = 0; i < 16; i++) enqueue(mk(CMD_SET_CAT, 16'h100 + 16'(i), 0, 4'h5, 0));
    enqueue(mk(CMD_MAP_KEY, 16'hBEEF, 10'h155, 0, 0));
    drain();
    // new random IDs for the random part; the table keeps its entries
    for (int i = 0; i < 24; i++) id_pool[i] = 16'($urandom);
    enqueue(mk(CMD_QUERY, id_pool[0], 0, 0, 0));
    drain();
    fill_random(400);
    drain();
    in_idle_pct = 81; fill_random(400);
    drain();
    in_idle_pct = 0; out_stall_pct = 81; fill_random(400);
    drain();
    in_idle_pct = 36; out_stall_pct = 36; fill_random(430);
    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/abt_pkg.sv
rtl/action_binding_table.sv
verif/tb.sv
